@@ sv/ctr_pkg.sv @@
// Constants, tables and helpers for the color temperature to RGB converter.
package ctr_pkg;

  localparam logic [24:0] DIV100_RECIP   = 25'd21474837;
  localparam logic [15:0] T_HIGH_KELVIN  = 16'd6600;
  localparam logic [15:0] T_BLUE_KELVIN  = 16'd1900;
  localparam logic [17:0] POW_SHIFT_Q8   = 18'd15360;
  localparam logic [17:0] BLUE_SHIFT_Q8  = 18'd2560;
  localparam logic [17:0] ONE_Q8         = 18'd256;

  localparam logic [23:0] GREEN_LOG_COEF = 24'd6518919;
  localparam logic [24:0] GREEN_LOG_OFFS = 25'd10559132;
  localparam logic [23:0] BLUE_LOG_COEF  = 24'd9077898;
  localparam logic [24:0] BLUE_LOG_OFFS  = 25'd19991416;
  localparam logic [24:0] RED_POW_COEF   = 25'd21607136;
  localparam logic [13:0] RED_POW_EXP    = 14'd8730;
  localparam logic [24:0] GREEN_POW_COEF = 25'd18882375;
  localparam logic [13:0] GREEN_POW_EXP  = 14'd4949;
  localparam logic [29:0] LN2_Q30        = 30'd744261118;

  localparam logic [16:0] LOG2_TAB [17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  localparam logic [17:0] EXP2_TAB [17] = '{
    18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
    18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
    18'd110218, 18'd115097, 18'd120194, 18'd125515, 18'd131072
  };

  typedef struct packed {
    logic hi;  // power curve branch
    logic bz;  // blue forced to zero
    logic gz;  // green log argument below one
  } flags_t;

  typedef struct packed {
    logic [17:0] mant;
    logic [3:0]  sh;
  } pow_mant_t;

  // 2^-y as mantissa and extra right shift, y is Q16
  function automatic pow_mant_t pow_mant(input logic [18:0] y);
    pow_mant_t   res;
    logic [16:0] u;
    logic [3:0]  i;
    logic [11:0] r;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [12:0] d;
    logic [25:0] prod;
    u = 17'h10000 - {1'b0, y[15:0]};
    i = u[15:12];
    r = u[11:0];
    lo = EXP2_TAB[i];
    hi = EXP2_TAB[5'({1'b0, i}) + 5'd1];
    d = 13'(hi - lo);
    prod = 26'(d * r) + 26'd2048;
    if (y[15:0] == 16'd0) begin
      res.mant = 18'd65536;
      res.sh = {1'b0, y[18:16]};
    end else begin
      res.mant = lo + 18'(prod[25:12]);
      res.sh = {1'b0, y[18:16]} + 4'd1;
    end
    return res;
  endfunction

  function automatic logic [7:0] clamp8(input logic [13:0] v);
    return (v > 14'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

@@ sv/ctr_log2.sv @@
// Two-stage log2 of a Q8 value, Q16 result, table with linear interpolation.
module ctr_log2 (
  input  logic        clk,
  input  logic [17:0] x,
  output logic [19:0] l2
);

  logic [4:0]  p;
  logic [37:0] norm;
  logic [3:0]  ip;
  logic [3:0]  idx;
  logic [15:0] rem;
  logic [16:0] lo;
  logic [16:0] hi;
  logic [12:0] d;
  logic [29:0] prod;

  always_comb begin
    p = '0;
    for (int i = 0; i < 18; i++) begin
      if (x[i]) p = 5'(i);
    end
    norm = {x, 20'd0} >> p;
  end

  always_ff @(posedge clk) begin
    ip  <= 4'(p - 5'd8);
    idx <= norm[19:16];
    rem <= norm[15:0];
  end

  always_comb begin
    lo = ctr_pkg::LOG2_TAB[idx];
    hi = ctr_pkg::LOG2_TAB[5'({1'b0, idx}) + 5'd1];
    d = 13'(hi - lo);
    prod = 30'(d * rem) + 30'd32768;
  end

  always_ff @(posedge clk) begin
    l2 <= {ip, 16'd0} + 20'(lo) + 20'(prod[29:16]);
  end

endmodule

@@ sv/color_temperature_to_rgb.sv @@
// Top level: pipelined color temperature to RGB converter.
//
//  channel  signals              dir  notes
//  command  start, busy, kelvin  in   beat taken when start && !busy
//  result   done, red/green/blue out  one-cycle strobe, no backpressure
//
// One beat per cycle. Eight register stages (input, divide, offsets, two
// log2, ln/exponent, curve, final product): done is registered alongside
// red/green/blue in the final stage. busy stays low.
// Synchronous reset clears the valid pipeline; payload registers are not
// reset.
module color_temperature_to_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] kelvin,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  logic [6:0] vld;

  logic [15:0] kel1;
  logic [17:0] tq2;
  logic [48:0] div_prod;
  logic [17:0] xa3;
  logic [17:0] xb3;
  logic [19:0] l2a5;
  logic [19:0] l2b5;
  logic [19:0] lna6;
  logic [19:0] lnb6;
  logic [18:0] yr6;
  logic [18:0] yg6;
  logic [50:0] lna_p;
  logic [50:0] lnb_p;
  logic [34:0] yr_p;
  logic [34:0] yg_p;
  logic [7:0]  glog7;
  logic [7:0]  blog7;
  ctr_pkg::pow_mant_t pr7;
  ctr_pkg::pow_mant_t pg7;
  logic [43:0] gv;
  logic [43:0] bv;
  logic [40:0] goff;
  logic [40:0] boff;
  logic [43:0] gdiff;
  logic [43:0] bdiff;
  logic [42:0] rprod;
  logic [42:0] gprod;
  logic [42:0] rsft;
  logic [42:0] gsft;
  logic [13:0] rcode;
  logic [13:0] gcode;
  ctr_pkg::flags_t fl2, fl3, fl4, fl5, fl6, fl7;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[5:0], start && !busy};
      done <= vld[6];
    end
  end

  // stage 1: input
  always_ff @(posedge clk) begin
    kel1 <= kelvin;
  end

  // stage 2: t in Q8 by reciprocal multiply
  assign div_prod = 49'(({kel1, 8'd0} + 24'd50) * ctr_pkg::DIV100_RECIP);

  always_ff @(posedge clk) begin
    tq2 <= div_prod[48:31];
    fl2.hi <= kel1 > ctr_pkg::T_HIGH_KELVIN;
    fl2.bz <= kel1 <= ctr_pkg::T_BLUE_KELVIN;
    fl2.gz <= 1'b0;
  end

  // stage 3: log arguments
  always_ff @(posedge clk) begin
    xa3 <= fl2.hi ? tq2 - ctr_pkg::POW_SHIFT_Q8 : tq2;
    xb3 <= tq2 - ctr_pkg::BLUE_SHIFT_Q8;
    fl3 <= '{hi: fl2.hi, bz: fl2.bz, gz: tq2 < ctr_pkg::ONE_Q8};
  end

  // stages 4-5: log2
  ctr_log2 u_log2_a (.clk(clk), .x(xa3), .l2(l2a5));
  ctr_log2 u_log2_b (.clk(clk), .x(xb3), .l2(l2b5));

  always_ff @(posedge clk) begin
    fl4 <= fl3;
    fl5 <= fl4;
  end

  // stage 6: ln and power exponents
  assign lna_p = 51'(l2a5 * ctr_pkg::LN2_Q30) + 51'(2**29);
  assign lnb_p = 51'(l2b5 * ctr_pkg::LN2_Q30) + 51'(2**29);
  assign yr_p  = 35'(l2a5 * ctr_pkg::RED_POW_EXP) + 35'd32768;
  assign yg_p  = 35'(l2a5 * ctr_pkg::GREEN_POW_EXP) + 35'd32768;

  always_ff @(posedge clk) begin
    lna6 <= lna_p[49:30];
    lnb6 <= lnb_p[49:30];
    yr6  <= yr_p[34:16];
    yg6  <= yg_p[34:16];
    fl6  <= fl5;
  end

  // stage 7: log curves, power mantissas
  always_comb begin
    gv = 44'(lna6 * ctr_pkg::GREEN_LOG_COEF);
    bv = 44'(lnb6 * ctr_pkg::BLUE_LOG_COEF);
    goff = {ctr_pkg::GREEN_LOG_OFFS, 16'd0};
    boff = {ctr_pkg::BLUE_LOG_OFFS, 16'd0};
    gdiff = gv - 44'(goff) + 44'(2**31);
    bdiff = bv - 44'(boff) + 44'(2**31);
  end

  always_ff @(posedge clk) begin
    glog7 <= (fl6.gz || gv <= 44'(goff)) ? 8'd0 : ctr_pkg::clamp8({2'b0, gdiff[43:32]});
    blog7 <= (fl6.bz || bv <= 44'(boff)) ? 8'd0 : ctr_pkg::clamp8({2'b0, bdiff[43:32]});
    pr7 <= ctr_pkg::pow_mant(yr6);
    pg7 <= ctr_pkg::pow_mant(yg6);
    fl7 <= fl6;
  end

  // stage 8: power products and output select
  always_comb begin
    rprod = 43'(pr7.mant * ctr_pkg::RED_POW_COEF);
    gprod = 43'(pg7.mant * ctr_pkg::GREEN_POW_COEF);
    rsft = rprod >> (6'd31 + 6'(pr7.sh));
    gsft = gprod >> (6'd31 + 6'(pg7.sh));
    rcode = 14'((rsft[13:0] + 14'd1) >> 1);
    gcode = 14'((gsft[13:0] + 14'd1) >> 1);
  end

  always_ff @(posedge clk) begin
    red   <= fl7.hi ? ctr_pkg::clamp8(rcode) : 8'hFF;
    green <= fl7.hi ? ctr_pkg::clamp8(gcode) : glog7;
    blue  <= fl7.hi ? 8'hFF : blog7;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##8 done)
    else $error("accepted beat did not produce a result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[6]))
    else $error("result without beat");

  a_low_red: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kelvin <= ctr_pkg::T_HIGH_KELVIN |-> ##8 (red == 8'hFF))
    else $error("red not full on log branch");

  a_high_blue: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kelvin > ctr_pkg::T_HIGH_KELVIN |-> ##8 (blue == 8'hFF))
    else $error("blue not full on power branch");
`endif

endmodule

@@ dv/tb.sv @@
// Testbench for the color temperature to RGB converter: random and directed kelvin beats.
`timescale 1ns / 1ps

class rgb_scoreboard;
  logic [23:0] pending[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  function void note_kelvin(logic [23:0] rgb);
    pending.push_back(rgb);
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [23:0] e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected beat %0d %0d %0d", r, g, b));
      return;
    end
    e = pending.pop_front();
    checked++;
    if (r !== e[23:16]) report($sformatf("red %0d exp %0d", r, e[23:16]));
    if (g !== e[15:8]) report($sformatf("green %0d exp %0d", g, e[15:8]));
    if (b !== e[7:0]) report($sformatf("blue %0d exp %0d", b, e[7:0]));
  endtask
endclass

module tb;

  localparam int WATCHDOG = 2000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] kelvin;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  rgb_scoreboard sb;
  int idle_pct;
  int sent;
  int stuck;

  localparam logic [16:0] LOG2_LUT [17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536
  };
  localparam logic [17:0] EXP2_LUT [17] = '{
    18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
    18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
    18'd110218, 18'd115097, 18'd120194, 18'd125515, 18'd131072
  };

  color_temperature_to_rgb u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kelvin(kelvin),
    .done(done), .red(red), .green(green), .blue(blue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned log2_of_q8(int unsigned x);
    int p;
    int unsigned f;
    int unsigned idx;
    int unsigned rem;
    longint unsigned lo;
    longint unsigned hi;
    p = 31;
    while (p > 0 && x[p] == 1'b0) p--;
    if (p >= 20) f = (x >> (p - 20)) & 32'hFFFFF;
    else f = (x << (20 - p)) & 32'hFFFFF;
    idx = f >> 16;
    rem = f & 32'hFFFF;
    lo = 64'(LOG2_LUT[5'(idx)]);
    hi = 64'(LOG2_LUT[5'(idx) + 5'd1]);
    return longint'(p - 8) * 65536 + lo + (((hi - lo) * rem + 32768) >> 16);
  endfunction

  function automatic logic [7:0] sat8(longint unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] log_level(int unsigned x, longint coef, longint offs);
    longint unsigned l2;
    longint ln;
    longint v;
    l2 = log2_of_q8(x);
    ln = longint'((l2 * 64'd744261118 + (64'd1 << 29)) >> 30);
    v = coef * ln - offs * 65536;
    if (v <= 0) return 8'd0;
    return sat8((longint'(unsigned'(v)) + (64'd1 << 31)) >> 32);
  endfunction

  function automatic logic [7:0] pow_level(int unsigned x, longint unsigned coef,
                                           longint unsigned p);
    longint unsigned l2;
    longint unsigned y;
    longint unsigned n;
    longint unsigned mant;
    longint unsigned sh;
    longint unsigned lo;
    longint unsigned hi;
    int unsigned fr;
    int unsigned u;
    l2 = log2_of_q8(x);
    y = (p * l2 + 32768) >> 16;
    n = y >> 16;
    fr = 32'(y & 64'hFFFF);
    if (n > 24) return 8'd0;
    if (fr == 0) begin
      mant = 65536;
      sh = n;
    end else begin
      u = 65536 - fr;
      lo = 64'(EXP2_LUT[5'(u >> 12)]);
      hi = 64'(EXP2_LUT[5'(u >> 12) + 5'd1]);
      mant = lo + (((hi - lo) * (u & 32'hFFF) + 2048) >> 12);
      sh = n + 1;
    end
    return sat8((coef * mant + (64'd1 << (31 + sh))) >> (32 + sh));
  endfunction

  function automatic logic [23:0] predict_rgb(logic [15:0] k);
    int unsigned tq;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    tq = (int'(k) * 256 + 50) / 100;
    if (k <= 16'd6600) begin
      r = 8'd255;
      g = (tq < 256) ? 8'd0 : log_level(tq, 6518919, 10559132);
      b = (k <= 16'd1900) ? 8'd0 : log_level(tq - 2560, 9077898, 19991416);
    end else begin
      r = pow_level(tq - 15360, 21607136, 8730);
      g = pow_level(tq - 15360, 18882375, 4949);
      b = 8'd255;
    end
    return {r, g, b};
  endfunction

  task automatic send_kelvin(logic [15:0] k);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kelvin <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_kelvin(predict_rgb(k));
    sent++;
  endtask

  task automatic run_phase(int pct, int count);
    int i;
    logic [15:0] k;
    idle_pct = pct;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: k = 16'($urandom_range(6600));
        1: k = 16'($urandom_range(20000, 6601));
        2: k = 16'($urandom_range(2000));
        default: k = 16'($urandom);
      endcase
      send_kelvin(k);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) sb.check_rgb(red, green, blue);
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WATCHDOG) begin
      $display("watchdog expired");
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    logic [15:0] directed[$];
    int n;
    sb = new();
    sent = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    kelvin = 16'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    directed = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd255, 16'd1000, 16'd1899,
                 16'd1900, 16'd1901, 16'd2000, 16'd6599, 16'd6600, 16'd6601,
                 16'd6700, 16'd10000, 16'd40000, 16'hFFFE, 16'hFFFF, 16'h5555,
                 16'hAAAA};
    foreach (directed[i]) send_kelvin(directed[i]);
    run_phase(0, 400);
    run_phase(73, 350);
    run_phase(19, 350);
    run_phase(0, 350);
    start <= 1'b0;
    n = 0;
    while (sb.pending.size() != 0 && n < 1000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
    $display("sent %0d kelvin beats, checked %0d rgb results", sent, sb.checked);
    $display("covered log and power branches, extremes, idle mixes 0/73/19");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
